// ===== rtl/core/isc_pkg.sv =====
// shared types, constants and codes of the ising chain spin update unit
package isc_pkg;

  localparam int unsigned MAX_SPINS = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_SPINS);
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned PROB_BITS = 16;
  localparam int unsigned THR_W     = PROB_BITS + 1;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SPINS);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(1 << PROB_BITS);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_LEN      = 3'd1,
    REG_UP_MINUS = 3'd2,
    REG_UP_ZERO  = 3'd3,
    REG_UP_PLUS  = 3'd4,
    REG_DN_MINUS = 3'd5,
    REG_DN_ZERO  = 3'd6,
    REG_DN_PLUS  = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_NBR_L,
    ST_NBR_R,
    ST_SITE,
    ST_EVAL,
    ST_MEAS,
    ST_MEAS_WRAP,
    ST_MEAS_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [ADDR_W-1:0]   site;
    logic                spin_value;
    logic [PROB_BITS-1:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic                    spin_changed;
    logic                    spin_after;
    logic signed [SUM_W-1:0] bond_sum;
    logic signed [SUM_W-1:0] magnetization;
    logic [CNT_W-1:0]        accepted_total;
  } out_item_t;

  typedef struct packed {
    logic                  metropolis;
    logic [LEN_W-1:0]      eff_len;
    logic [2:0][THR_W-1:0] thr_up;
    logic [2:0][THR_W-1:0] thr_dn;
  } cfg_t;

  typedef struct packed {
    logic                    spin_changed;
    logic                    spin_after;
    logic signed [SUM_W-1:0] bond_sum;
    logic signed [SUM_W-1:0] magnetization;
  } res_t;

  typedef struct packed {
    logic res_valid;
    logic busy;
  } core_stat_t;

endpackage

// ===== rtl/core/ising_chain_spin_update_unit.sv =====
// top level of the ising chain spin update unit with output register
// One command is taken at a time and in_stall_o stays high until its result has been
// handed to the output register; that register lets the next command be taken while the
// result still waits downstream. Every spin goes through the single read port of the spin
// ram, one spin per cycle: an update reads the left, right and own spin in turn, then makes
// one threshold compare and the write back, and measure walks the whole ring. Spins are
// not cleared at reset and every active site must be written before it is updated or
// measured.
module ising_chain_spin_update_unit
  import isc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  cfg_t             cfg;
  core_stat_t       stat;
  res_t             res;
  logic [CNT_W-1:0] acc;
  logic             start;
  logic             take;
  logic             load;
  logic             out_vld_q;
  out_item_t        out_q;

  isc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  isc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start_i    (start),
    .item_i     (in_data_i),
    .res_take_i (take),
    .stat_o     (stat),
    .res_o      (res),
    .acc_o      (acc)
  );

  assign in_stall_o = stat.busy;
  assign start      = in_valid_i && !stat.busy;
  assign take       = !out_vld_q || !out_stall_i;
  assign load       = stat.res_valid && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.spin_changed   <= res.spin_changed;
      out_q.spin_after     <= res.spin_after;
      out_q.bond_sum       <= res.bond_sum;
      out_q.magnetization  <= res.magnetization;
      out_q.accepted_total <= acc;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("result load did not raise out_valid_o");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("block not busy after accepting a transaction");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !load) |=> !out_valid_o)
    else $error("taken result still shown without a new load");

  a_done_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.res_valid && !take) |=> (stat.res_valid && in_stall_o))
    else $error("pending result dropped while output register full");

endmodule

// ===== rtl/core/isc_ram.sv =====
// generic single-write, single-read ram with registered read data
module isc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/isc_cfg.sv =====
// apb configuration registers and ring length clamp
module isc_cfg
  import isc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic                  mode_q;
  logic [LEN_W-1:0]      len_q;
  logic [2:0][THR_W-1:0] up_q;
  logic [2:0][THR_W-1:0] dn_q;
  logic                  wr_en;
  reg_e                  idx;
  logic [THR_W-1:0]      wthr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[PADDR_W-1:2]);
  assign wthr   = pwdata[THR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      len_q  <= MAX_LEN;
      up_q   <= {3{THR_RST}};
      dn_q   <= {3{THR_RST}};
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:     mode_q   <= pwdata[0];
        REG_LEN:      len_q    <= pwdata[LEN_W-1:0];
        REG_UP_MINUS: up_q[0]  <= wthr;
        REG_UP_ZERO:  up_q[1]  <= wthr;
        REG_UP_PLUS:  up_q[2]  <= wthr;
        REG_DN_MINUS: dn_q[0]  <= wthr;
        REG_DN_ZERO:  dn_q[1]  <= wthr;
        REG_DN_PLUS:  dn_q[2]  <= wthr;
        default:      mode_q   <= mode_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:     prdata = PDATA_W'(mode_q);
      REG_LEN:      prdata = PDATA_W'(len_q);
      REG_UP_MINUS: prdata = PDATA_W'(up_q[0]);
      REG_UP_ZERO:  prdata = PDATA_W'(up_q[1]);
      REG_UP_PLUS:  prdata = PDATA_W'(up_q[2]);
      REG_DN_MINUS: prdata = PDATA_W'(dn_q[0]);
      REG_DN_ZERO:  prdata = PDATA_W'(dn_q[1]);
      REG_DN_PLUS:  prdata = PDATA_W'(dn_q[2]);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.metropolis = mode_q;
    cfg_o.thr_up     = up_q;
    cfg_o.thr_dn     = dn_q;
    if (len_q < MIN_LEN) begin
      cfg_o.eff_len = MIN_LEN;
    end else if (len_q > MAX_LEN) begin
      cfg_o.eff_len = MAX_LEN;
    end else begin
      cfg_o.eff_len = len_q;
    end
  end

endmodule

// ===== rtl/core/isc_core.sv =====
// command sequencer, spin ram and shared threshold compare
module isc_core
  import isc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       start_i,
  input  in_item_t   item_i,
  input  logic       res_take_i,
  output core_stat_t stat_o,
  output res_t       res_o,
  output logic [CNT_W-1:0] acc_o
);

  state_e                  state_q, state_d;
  in_item_t                item_q;
  res_t                    res_q, res_d;
  logic [CNT_W-1:0]        acc_q, acc_d;
  logic [1:0]              nb_q, nb_d;
  logic [ADDR_W-1:0]       idx_q, idx_d;
  logic                    meas_vld_q;
  logic                    meas_first_q;
  logic                    first_q;
  logic                    prev_q;
  logic signed [SUM_W-1:0] bond_q;
  logic signed [SUM_W-1:0] mag_q;

  logic                    ram_we;
  logic                    ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic                    ram_rdata;

  logic                    site_ok;
  logic [ADDR_W-1:0]       left_addr;
  logic [ADDR_W-1:0]       right_addr;
  logic [ADDR_W-1:0]       last_addr;
  logic [THR_W-1:0]        cmp_thr;
  logic                    pass;
  logic                    new_spin;

  isc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SPINS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_q.site),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_addr  = ADDR_W'(cfg_i.eff_len - LEN_W'(1));
  assign site_ok    = {1'b0, item_q.site} < cfg_i.eff_len;
  assign left_addr  = (item_q.site == '0) ? last_addr : item_q.site - ADDR_W'(1);
  assign right_addr = ({1'b0, item_q.site} + LEN_W'(1) == cfg_i.eff_len) ?
                      '0 : item_q.site + ADDR_W'(1);

  // one compare serves both metropolis and gibbs tests
  assign cmp_thr  = (cfg_i.metropolis && !ram_rdata) ? cfg_i.thr_dn[nb_q] : cfg_i.thr_up[nb_q];
  assign pass     = {1'b0, item_q.random_draw} < cmp_thr;
  assign new_spin = cfg_i.metropolis ? (ram_rdata ^ pass) : pass;

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    acc_d     = acc_q;
    nb_d      = nb_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;
    ram_wdata = item_q.spin_value;
    ram_raddr = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (item_i.command)
            CMD_UPDATE:  state_d = ST_NBR_L;
            CMD_MEASURE: state_d = ST_MEAS;
            CMD_WRITE,
            CMD_CLEAR:   state_d = ST_SIMPLE;
            default:     state_d = ST_SIMPLE;
          endcase
          idx_d = '0;
        end
      end
      ST_SIMPLE: begin
        res_d = '0;
        if (item_q.command == CMD_CLEAR) begin
          acc_d = '0;
        end else if (site_ok) begin
          ram_we           = 1'b1;
          res_d.spin_after = item_q.spin_value;
        end
        state_d = ST_DONE;
      end
      ST_NBR_L: begin
        res_d     = '0;
        ram_raddr = left_addr;
        state_d   = site_ok ? ST_NBR_R : ST_DONE;
      end
      ST_NBR_R: begin
        ram_raddr = right_addr;
        nb_d      = {1'b0, ram_rdata};
        state_d   = ST_SITE;
      end
      ST_SITE: begin
        ram_raddr = item_q.site;
        nb_d      = nb_q + {1'b0, ram_rdata};
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        ram_we             = 1'b1;
        ram_wdata          = new_spin;
        res_d.spin_after   = new_spin;
        res_d.spin_changed = new_spin ^ ram_rdata;
        if (cfg_i.metropolis && pass) begin
          acc_d = acc_q + CNT_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_MEAS: begin
        ram_raddr = idx_q;
        idx_d     = idx_q + ADDR_W'(1);
        if (idx_q == last_addr) begin
          state_d = ST_MEAS_WRAP;
        end
      end
      ST_MEAS_WRAP: begin
        state_d = ST_MEAS_FIN;
      end
      ST_MEAS_FIN: begin
        res_d               = '0;
        res_d.bond_sum      = bond_q + ((prev_q == first_q) ? SUM_W'(1) : '1);
        res_d.magnetization = mag_q;
        state_d             = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      acc_q        <= '0;
      meas_vld_q   <= 1'b0;
      meas_first_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      meas_vld_q <= (state_q == ST_MEAS);
      if (state_q == ST_IDLE) begin
        meas_first_q <= 1'b1;
      end else if (meas_vld_q) begin
        meas_first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q <= item_i;
    end
    res_q <= res_d;
    nb_q  <= nb_d;
    idx_q <= idx_d;
    if (meas_vld_q) begin
      prev_q <= ram_rdata;
      if (meas_first_q) begin
        first_q <= ram_rdata;
        bond_q  <= '0;
        mag_q   <= ram_rdata ? SUM_W'(1) : '1;
      end else begin
        bond_q <= bond_q + ((prev_q == ram_rdata) ? SUM_W'(1) : '1);
        mag_q  <= mag_q + (ram_rdata ? SUM_W'(1) : '1);
      end
    end
  end

  assign stat_o.res_valid = (state_q == ST_DONE);
  assign stat_o.busy      = (state_q != ST_IDLE);
  assign res_o            = res_q;
  assign acc_o            = acc_q;

endmodule

// ===== tb/tb_ising_chain_spin_update_unit.sv =====
// testbench for the ising chain spin update unit: directed and random command streams checked against a predictor
`timescale 1ns / 1ps

module tb_ising_chain_spin_update_unit;
  import isc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 150;
  localparam int NUM_PHASES  = 8;

  localparam int THR_RANDOM = 0;
  localparam int THR_ALWAYS = 1;
  localparam int THR_NEVER  = 2;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  in_item_t           cmd_data = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  out_item_t          res_data;

  ising_chain_spin_update_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_data_i   (cmd_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  logic             metropolis_on = 1'b1;
  logic [LEN_W-1:0] ring_len_cfg = MAX_LEN;
  logic [THR_W-1:0] thr_up_cfg [3] = '{THR_RST, THR_RST, THR_RST};
  logic [THR_W-1:0] thr_dn_cfg [3] = '{THR_RST, THR_RST, THR_RST};
  logic             ring_spins [MAX_SPINS];
  bit               site_loaded [MAX_SPINS];
  logic [CNT_W-1:0] flip_count = '0;

  in_item_t  pending_cmds [$];
  out_item_t expected_results [$];
  out_item_t want_res;

  int  phase_mode  [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};
  int  phase_len   [NUM_PHASES] = '{16, 5, 2047, 1, 1024, 200, 40, 64};
  int  phase_items [NUM_PHASES] = '{120, 80, 150, 60, 80, 120, 60, 130};
  int  phase_thr   [NUM_PHASES] = '{THR_RANDOM, THR_RANDOM, THR_ALWAYS, THR_NEVER,
                                    THR_RANDOM, THR_RANDOM, THR_RANDOM, THR_RANDOM};
  bit  phase_calm  [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 1};

  bit  calm = 1'b0;
  bit  cmd_taken = 1'b0;
  bit  hold_done = 1'b0;
  int  src_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  error_count = 0;
  int  results_seen = 0;
  int  cmds_taken = 0;
  int  n_updates = 0;
  int  n_measures = 0;
  int  n_flips = 0;
  int  n_settings = 0;
  int  counted;
  bit  drv_valid;
  bit  drv_stall;
  in_item_t drv_data;

  initial begin
    foreach (ring_spins[i]) ring_spins[i] = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int eff_len();
    int n;
    n = int'(ring_len_cfg);
    if (n < 3) n = 3;
    if (n > int'(MAX_SPINS)) n = int'(MAX_SPINS);
    return n;
  endfunction

  function automatic out_item_t apply_spin_command(in_item_t it);
    out_item_t        r;
    int               n;
    int               site;
    int               left;
    int               right;
    int               nb;
    int               nxt;
    int               bonds;
    int               mag;
    logic             old_spin;
    logic             new_spin;
    logic [THR_W-1:0] thr;
    r = '0;
    n = eff_len();
    site = int'(it.site);
    bonds = 0;
    mag = 0;
    case (it.command)
      CMD_WRITE: begin
        if (site < n) begin
          ring_spins[site] = it.spin_value;
          r.spin_after = it.spin_value;
        end
      end
      CMD_UPDATE: begin
        if (site < n) begin
          left = (site == 0) ? n - 1 : site - 1;
          right = (site + 1 == n) ? 0 : site + 1;
          nb = int'(ring_spins[left]) + int'(ring_spins[right]);
          old_spin = ring_spins[site];
          new_spin = old_spin;
          if (metropolis_on) begin
            thr = old_spin ? thr_up_cfg[nb] : thr_dn_cfg[nb];
            if ({1'b0, it.random_draw} < thr) begin
              new_spin = ~old_spin;
              flip_count = flip_count + 1'b1;
            end
          end else begin
            new_spin = ({1'b0, it.random_draw} < thr_up_cfg[nb]);
          end
          ring_spins[site] = new_spin;
          r.spin_changed = (new_spin != old_spin);
          r.spin_after = new_spin;
        end
      end
      CMD_MEASURE: begin
        for (int i = 0; i < n; i++) begin
          nxt = (i + 1 == n) ? 0 : i + 1;
          bonds += (ring_spins[i] == ring_spins[nxt]) ? 1 : -1;
          mag += ring_spins[i] ? 1 : -1;
        end
        r.bond_sum = SUM_W'(bonds);
        r.magnetization = SUM_W'(mag);
      end
      default: begin
        flip_count = '0;
      end
    endcase
    r.accepted_total = flip_count;
    return r;
  endfunction

  function automatic void push_cmd(cmd_e c, int site, bit v, int draw);
    in_item_t it;
    it.command = c;
    it.site = ADDR_W'(site);
    it.spin_value = v;
    it.random_draw = PROB_BITS'(draw);
    if (c == CMD_WRITE && site < eff_len()) site_loaded[site] = 1'b1;
    pending_cmds.push_back(it);
  endfunction

  // returns 0 for a command that the block ignores
  function automatic bit queue_random_command(int n);
    int pick;
    int site;
    int draw;
    bit v;
    pick = $urandom_range(0, 99);
    site = $urandom_range(0, n - 1);
    v = $urandom_range(0, 1);
    if ($urandom_range(0, 9) == 0) draw = 0;
    else if ($urandom_range(0, 9) == 0) draw = 65535;
    else draw = $urandom_range(0, 65535);
    if (pick < 30) begin
      push_cmd(CMD_WRITE, site, v, draw);
    end else if (pick < 86) begin
      push_cmd(CMD_UPDATE, site, v, draw);
    end else if (pick < 90) begin
      if (n < int'(MAX_SPINS)) begin
        push_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_UPDATE,
                 $urandom_range(n, MAX_SPINS - 1), v, draw);
        return 1'b0;
      end
      push_cmd(CMD_UPDATE, site, v, draw);
    end else if (pick < 94) begin
      push_cmd(CMD_CLEAR, $urandom_range(0, MAX_SPINS - 1), v, draw);
    end else if (n <= 128 || $urandom_range(0, 7) == 0) begin
      push_cmd(CMD_MEASURE, $urandom_range(0, MAX_SPINS - 1), v, draw);
    end else begin
      push_cmd(CMD_UPDATE, site, v, draw);
    end
    return 1'b1;
  endfunction

  function automatic int pick_threshold(int kind);
    if (kind == THR_ALWAYS) return 65536;
    if (kind == THR_NEVER) return 0;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      3: return 1;
      4: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic write_reg(input reg_e idx, input int val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MODE:     metropolis_on = val[0];
      REG_LEN:      ring_len_cfg = val[LEN_W-1:0];
      REG_UP_MINUS: thr_up_cfg[0] = val[THR_W-1:0];
      REG_UP_ZERO:  thr_up_cfg[1] = val[THR_W-1:0];
      REG_UP_PLUS:  thr_up_cfg[2] = val[THR_W-1:0];
      REG_DN_MINUS: thr_dn_cfg[0] = val[THR_W-1:0];
      REG_DN_ZERO:  thr_dn_cfg[1] = val[THR_W-1:0];
      default:      thr_dn_cfg[2] = val[THR_W-1:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_block(input int mode, input int len, input int up0, input int up1,
                               input int up2, input int dn0, input int dn1, input int dn2);
    write_reg(REG_MODE, mode);
    write_reg(REG_LEN, len);
    write_reg(REG_UP_MINUS, up0);
    write_reg(REG_UP_ZERO, up1);
    write_reg(REG_UP_PLUS, up2);
    write_reg(REG_DN_MINUS, dn0);
    write_reg(REG_DN_ZERO, dn1);
    write_reg(REG_DN_PLUS, dn2);
    n_settings++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (!(pending_cmds.size() == 0 && !cmd_valid && expected_results.size() == 0));
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      drv_valid = cmd_valid;
      drv_data = cmd_data;
      if (cmd_valid && cmd_taken) begin
        drv_valid = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 7);
      end
      if (!drv_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_cmds.size() > 0) begin
          drv_data = pending_cmds.pop_front();
          drv_valid = 1'b1;
        end
      end
      cmd_valid <= drv_valid;
      cmd_data <= drv_data;
    end
  end

  // result stall generator, with one long hold-off
  always @(negedge clk_i) begin
    if (!calm && !hold_done && results_seen >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      drv_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      drv_stall = 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      drv_stall = 1'b1;
    end else begin
      drv_stall = 1'b0;
    end
    res_stall <= drv_stall;
  end

  // transaction monitor and checker
  always @(posedge clk_i) begin
    cmd_taken = rst_ni && cmd_valid && !cmd_stall;
    if (cmd_taken) begin
      want_res = apply_spin_command(cmd_data);
      expected_results.push_back(want_res);
      cmds_taken++;
      if (cmd_data.command == CMD_UPDATE) n_updates++;
      if (cmd_data.command == CMD_MEASURE) n_measures++;
      if (want_res.spin_changed) n_flips++;
    end
    if (rst_ni && res_valid && !res_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want_res = expected_results.pop_front();
        if (res_data.spin_changed !== want_res.spin_changed)
          report_mismatch($sformatf("result %0d spin_changed got %0d want %0d", results_seen,
                                    res_data.spin_changed, want_res.spin_changed));
        if (res_data.spin_after !== want_res.spin_after)
          report_mismatch($sformatf("result %0d spin_after got %0d want %0d", results_seen,
                                    res_data.spin_after, want_res.spin_after));
        if (res_data.bond_sum !== want_res.bond_sum)
          report_mismatch($sformatf("result %0d bond_sum got %0d want %0d", results_seen,
                                    res_data.bond_sum, want_res.bond_sum));
        if (res_data.magnetization !== want_res.magnetization)
          report_mismatch($sformatf("result %0d magnetization got %0d want %0d", results_seen,
                                    res_data.magnetization, want_res.magnetization));
        if (res_data.accepted_total !== want_res.accepted_total)
          report_mismatch($sformatf("result %0d accepted_total got %0d want %0d", results_seen,
                                    res_data.accepted_total, want_res.accepted_total));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("ising_chain_spin_update_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short ring (length register below minimum), metropolis, extreme thresholds
    program_block(1, 0, 0, 65536, 131071, 1, 65535, 32768);
    push_cmd(CMD_WRITE, 0, 1'b1, 0);
    push_cmd(CMD_WRITE, 1, 1'b0, 65535);
    push_cmd(CMD_WRITE, 2, 1'b1, 0);
    push_cmd(CMD_WRITE, 3, 1'b1, 0);
    push_cmd(CMD_WRITE, 1023, 1'b0, 0);
    push_cmd(CMD_MEASURE, 0, 1'b0, 0);
    push_cmd(CMD_UPDATE, 1, 1'b0, 0);
    push_cmd(CMD_UPDATE, 1, 1'b1, 65535);
    push_cmd(CMD_UPDATE, 0, 1'b0, 65535);
    push_cmd(CMD_UPDATE, 2, 1'b0, 0);
    push_cmd(CMD_UPDATE, 1023, 1'b1, 0);
    push_cmd(CMD_MEASURE, 1023, 1'b1, 65535);
    push_cmd(CMD_CLEAR, 0, 1'b0, 0);
    push_cmd(CMD_UPDATE, 0, 1'b0, 0);
    push_cmd(CMD_MEASURE, 0, 1'b0, 0);
    wait_idle();

    // gibbs sampling on the same ring
    program_block(0, 3, 65536, 0, 1, 0, 0, 0);
    push_cmd(CMD_UPDATE, 0, 1'b0, 0);
    push_cmd(CMD_UPDATE, 1, 1'b1, 65535);
    push_cmd(CMD_UPDATE, 2, 1'b0, 1);
    push_cmd(CMD_UPDATE, 0, 1'b1, 65535);
    push_cmd(CMD_UPDATE, 3, 1'b1, 0);
    push_cmd(CMD_MEASURE, 0, 1'b0, 0);
    push_cmd(CMD_CLEAR, 1023, 1'b1, 65535);
    push_cmd(CMD_MEASURE, 0, 1'b0, 0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_block(phase_mode[p], phase_len[p],
                    pick_threshold(phase_thr[p]), pick_threshold(phase_thr[p]),
                    pick_threshold(phase_thr[p]), pick_threshold(phase_thr[p]),
                    pick_threshold(phase_thr[p]), pick_threshold(phase_thr[p]));
      calm = phase_calm[p];
      for (int s = 0; s < eff_len(); s++)
        if (!site_loaded[s])
          push_cmd(CMD_WRITE, s, $urandom_range(0, 1), $urandom_range(0, 65535));
      counted = 0;
      while (counted < phase_items[p])
        counted += queue_random_command(eff_len());
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d commands checked: %0d updates with %0d spin changes, %0d ring measurements",
             cmds_taken, n_updates, n_flips, n_measures);
    $display("%0d register settings across both sampling modes, ring lengths 3 to %0d",
             n_settings, MAX_SPINS);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ising_chain_spin_update_unit: match");
    end else begin
      $display("ising_chain_spin_update_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== ising_chain_spin_update_unit.f =====
rtl/core/isc_pkg.sv
rtl/core/isc_ram.sv
rtl/core/isc_cfg.sv
rtl/core/isc_core.sv
rtl/core/ising_chain_spin_update_unit.sv
tb/tb_ising_chain_spin_update_unit.sv
